>>> rtl/sit_pkg.sv
// shared types, constants and helpers of the symbol intern table
package sit_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int WORD_W  = 32;
    localparam int PAIR_W  = 2 * WORD_W;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        OP_SEARCH = 1'b0,
        OP_INTERN = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // one name split over the three stores
    typedef struct packed {
        logic [PAIR_W-1:0] hi;
        logic [PAIR_W-1:0] mid;
        logic [PAIR_W-1:0] lo;
    } t_name;

    // sequencer requests to the name stores
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
    } t_ram_req;

    // low 8 bits of an entry number, zero extended for small tables
    function automatic logic [7:0] to_index(input logic [CNT_W-1:0] v);
        logic [CNT_W+7:0] t;
        t = {8'b0, v};
        return t[7:0];
    endfunction

endpackage

>>> rtl/sit_if.sv
// request and response channel interfaces of the symbol intern table
interface sit_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [sit_pkg::WORD_W-1:0]    name_word0;
    logic [sit_pkg::WORD_W-1:0]    name_word1;
    logic [sit_pkg::WORD_W-1:0]    name_word2;
    logic [sit_pkg::WORD_W-1:0]    name_word3;
    logic [sit_pkg::WORD_W-1:0]    name_word4;
    logic [sit_pkg::WORD_W-1:0]    name_word5;

    modport source (
        output valid, opcode, name_word0, name_word1, name_word2,
               name_word3, name_word4, name_word5,
        input  ready
    );
    modport sink (
        input  valid, opcode, name_word0, name_word1, name_word2,
               name_word3, name_word4, name_word5,
        output ready
    );
endinterface

interface sit_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] entry_index;

    modport source (output valid, status, entry_index, input ready);
    modport sink   (input valid, status, entry_index, output ready);
endinterface

>>> rtl/sit_ram.sv
// generic simple dual port ram with registered read
module sit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/sit_cmp.sv
// shared name comparator: stored entry against the request key
module sit_cmp (
    input  sit_pkg::t_name i_stored,
    input  sit_pkg::t_name i_key,
    output logic           o_match
);
    logic m_lo, m_mid, m_hi;

    assign m_lo    = (i_stored.lo  == i_key.lo);
    assign m_mid   = (i_stored.mid == i_key.mid);
    assign m_hi    = (i_stored.hi  == i_key.hi);
    assign o_match = m_lo & m_mid & m_hi;
endmodule

>>> rtl/sit_ctrl.sv
// scan sequencer, fill count and result register of the symbol intern table
module sit_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sit_req_if.sink           i_req,
    sit_rsp_if.source         o_rsp,
    input  logic              i_match,
    output sit_pkg::t_ram_req o_ram,
    output sit_pkg::t_name    o_key
);
    sit_pkg::t_state              r_state, n_state;
    sit_pkg::t_name               r_key, n_key;
    logic                         r_op, n_op;
    logic [sit_pkg::CNT_W-1:0]    r_limit, n_limit;
    logic [sit_pkg::CNT_W-1:0]    r_rd_idx, n_rd_idx;
    logic                         r_cmp_vld, n_cmp_vld;
    logic [sit_pkg::IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic [sit_pkg::CNT_W-1:0]    r_fill, n_fill;
    sit_pkg::t_status             r_res_status, n_res_status;
    logic [7:0]                   r_res_idx, n_res_idx;
    logic                         r_out_valid, n_out_valid;
    sit_pkg::t_status             r_out_status, n_out_status;
    logic [7:0]                   r_out_idx, n_out_idx;
    logic                         issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sit_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_cmp_vld   <= n_cmp_vld;
        end
        r_key        <= n_key;
        r_op         <= n_op;
        r_limit      <= n_limit;
        r_rd_idx     <= n_rd_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
    end

    assign issue = (r_rd_idx < r_limit);

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_op         = r_op;
        n_limit      = r_limit;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_fill       = r_fill;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        o_ram        = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            sit_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_key.lo  = {i_req.name_word1, i_req.name_word0};
                    n_key.mid = {i_req.name_word3, i_req.name_word2};
                    n_key.hi  = {i_req.name_word5, i_req.name_word4};
                    n_op      = i_req.opcode;
                    n_limit   = r_fill;
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = sit_pkg::S_SCAN;
                end
            end
            sit_pkg::S_SCAN: begin
                // one read issued per cycle, compared the cycle after
                n_cmp_vld = issue;
                if (issue) begin
                    o_ram.rd_en = 1'b1;
                    o_ram.raddr = r_rd_idx[sit_pkg::IDX_W-1:0];
                    n_rd_idx    = r_rd_idx + sit_pkg::CNT_W'(1);
                    n_cmp_idx   = r_rd_idx[sit_pkg::IDX_W-1:0];
                end
                priority if (r_cmp_vld && i_match) begin
                    n_res_status = sit_pkg::ST_FOUND;
                    n_res_idx    = sit_pkg::to_index(sit_pkg::CNT_W'(r_cmp_idx));
                    n_cmp_vld    = 1'b0;
                    n_state      = sit_pkg::S_DONE;
                end else if (!r_cmp_vld && !issue) begin
                    n_state = sit_pkg::S_DONE;
                    priority if (r_op == sit_pkg::OP_SEARCH) begin
                        n_res_status = sit_pkg::ST_NOT_FOUND;
                        n_res_idx    = '0;
                    end else if (r_limit == sit_pkg::CNT_W'(sit_pkg::ENTRIES)) begin
                        n_res_status = sit_pkg::ST_FULL;
                        n_res_idx    = '0;
                    end else begin
                        o_ram.we     = 1'b1;
                        o_ram.waddr  = r_limit[sit_pkg::IDX_W-1:0];
                        n_fill       = r_limit + sit_pkg::CNT_W'(1);
                        n_res_status = sit_pkg::ST_INSERTED;
                        n_res_idx    = sit_pkg::to_index(r_limit);
                    end
                end else begin
                    n_state = sit_pkg::S_SCAN;
                end
            end
            sit_pkg::S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = r_res_idx;
                    n_state      = sit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sit_pkg::S_IDLE;
            end
        endcase
    end

    assign i_req.ready       = (r_state == sit_pkg::S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_index = r_out_idx;
    assign o_key             = r_key;
endmodule

>>> rtl/symbol_intern_table_core.sv
// top level of the symbol intern table: name stores, comparator and sequencer
//
// symbol intern table with a linear scan. each request item carries a
// 24-byte zero padded name as six 32-bit words and an opcode (search, or
// intern). the name is compared against the filled entries lowest index
// first, one entry per clock through a single shared 192-bit comparator fed
// by the read port of the three name stores. a hit returns found and the
// index; a miss returns not found for a search, appends the name and returns
// inserted for an intern, or returns table full when every entry is in use.
// the scan stops at the first hit, while a miss reads every filled entry;
// the scan length is set by the one read port of the name stores.
// the request side is not ready during a scan and takes the next request from
// the cycle after the result is loaded; a finished result sits in an output
// register, so the next request can be taken while it waits. entries are only
// read after they are written, so the stores need no clearing after reset.
module symbol_intern_table_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sit_req_if.sink   i_req,
    sit_rsp_if.source o_rsp
);
    sit_pkg::t_ram_req ram_req;
    sit_pkg::t_name    key;
    sit_pkg::t_name    stored;
    logic              match;

    // sequencer: owns the fill count, the scan index and the result register
    sit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_match (match),
        .o_ram   (ram_req),
        .o_key   (key)
    );

    // name words 1:0
    sit_ram #(.WIDTH(sit_pkg::PAIR_W), .DEPTH(sit_pkg::ENTRIES)) u_store_low (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (key.lo),
        .i_re    (ram_req.rd_en),
        .i_raddr (ram_req.raddr),
        .o_rdata (stored.lo)
    );

    // name words 3:2
    sit_ram #(.WIDTH(sit_pkg::PAIR_W), .DEPTH(sit_pkg::ENTRIES)) u_store_mid (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (key.mid),
        .i_re    (ram_req.rd_en),
        .i_raddr (ram_req.raddr),
        .o_rdata (stored.mid)
    );

    // name words 5:4
    sit_ram #(.WIDTH(sit_pkg::PAIR_W), .DEPTH(sit_pkg::ENTRIES)) u_store_high (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (key.hi),
        .i_re    (ram_req.rd_en),
        .i_raddr (ram_req.raddr),
        .o_rdata (stored.hi)
    );

    // the one comparator, reused for every entry of the scan
    sit_cmp u_cmp (
        .i_stored (stored),
        .i_key    (key),
        .o_match  (match)
    );
endmodule

>>> tb/symbol_intern_table_core_test.sv
// self-checking testbench of the symbol intern table with a scoreboard class
`timescale 1ns / 100ps

// one expected reply of the table
typedef struct {
    sit_pkg::t_status status;
    logic [7:0]       index;
} t_reply;

// keeps its own copy of the name table and the replies still owed by the block
class intern_checker;
    sit_pkg::t_name known_names [sit_pkg::ENTRIES];
    int unsigned    known_count;
    t_reply         awaited_replies [$];
    int unsigned    faults;
    int unsigned    tally [4];

    function new();
        known_count = 0;
        faults      = 0;
        foreach (tally[k]) tally[k] = 0;
    endfunction

    // works out the reply of one accepted request and updates the table copy
    function void note_request(input sit_pkg::t_opcode op, input sit_pkg::t_name nm);
        t_reply want;
        int     hit;
        hit = -1;
        // lowest matching entry wins
        for (int k = 0; k < known_count && hit < 0; k++)
            if (known_names[k] == nm) hit = k;
        if (hit >= 0) begin
            want = '{sit_pkg::ST_FOUND, 8'(hit)};
        end else if (op == sit_pkg::OP_SEARCH) begin
            want = '{sit_pkg::ST_NOT_FOUND, 8'd0};
        end else if (known_count >= sit_pkg::ENTRIES) begin
            want = '{sit_pkg::ST_FULL, 8'd0};
        end else begin
            known_names[known_count] = nm;
            want = '{sit_pkg::ST_INSERTED, 8'(known_count)};
            known_count++;
        end
        awaited_replies.push_back(want);
    endfunction

    function void complain(input string what);
        faults++;
        if (faults <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function void check_reply(input sit_pkg::t_status got_status,
                              input logic [7:0] got_index);
        t_reply want;
        if (awaited_replies.size() == 0) begin
            complain($sformatf("reply with none awaited: status %0d index %0d",
                               got_status, got_index));
            return;
        end
        want = awaited_replies.pop_front();
        tally[want.status]++;
        if (got_status !== want.status)
            complain($sformatf("status expected %0d got %0d", want.status, got_status));
        if (got_index !== want.index)
            complain($sformatf("entry index expected %0d got %0d", want.index, got_index));
    endfunction

    function int unsigned outstanding();
        return awaited_replies.size();
    endfunction
endclass

module symbol_intern_table_core_test;

    localparam int          N_RANDOM    = 1980;
    localparam int          CALM_ITEMS  = 300;
    localparam int          HOLD_CYCLES = 700;
    localparam int          NAME_W      = 3 * sit_pkg::PAIR_W;
    // slowest run is about 2000 items of full scans plus stalls, taken five times over
    localparam int unsigned TIMEOUT_NS  = 30_000_000;

    logic i_clk;
    logic i_rst_n;

    sit_req_if req_ch ();
    sit_rsp_if rsp_ch ();

    symbol_intern_table_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    intern_checker sb = new();

    // every name offered so far, to draw repeats and near misses from
    sit_pkg::t_name sent_names [$];
    // idling policy shared by sender and receiver
    bit    calm;
    bit    lazy;
    bit    hold_wanted;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // accepted requests feed the predictor before replies are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(sit_pkg::t_opcode'(req_ch.opcode),
                                sit_pkg::t_name'({req_ch.name_word5, req_ch.name_word4,
                                                  req_ch.name_word3, req_ch.name_word2,
                                                  req_ch.name_word1, req_ch.name_word0}));
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_reply(sit_pkg::t_status'(rsp_ch.status), rsp_ch.entry_index);
        end
    end

    // reply side: random stalls, long hold-offs on demand, none in the calm tail
    initial begin
        rsp_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (calm) begin
                rsp_ch.ready <= 1'b1;
                @(negedge i_clk);
            end else if ($urandom_range(0, 99) < 15) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // holds one request item until the block takes it, returns at a falling edge
    task automatic request(input sit_pkg::t_opcode op, input sit_pkg::t_name nm);
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.name_word0 <= nm.lo[31:0];
        req_ch.name_word1 <= nm.lo[63:32];
        req_ch.name_word2 <= nm.mid[31:0];
        req_ch.name_word3 <= nm.mid[63:32];
        req_ch.name_word4 <= nm.hi[31:0];
        req_ch.name_word5 <= nm.hi[63:32];
        sent_names.push_back(nm);
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (!calm && lazy && $urandom_range(0, 2) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    function automatic sit_pkg::t_name one_word_name(input int w, input logic [31:0] v);
        logic [NAME_W-1:0] bits;
        bits = '0;
        bits[w*sit_pkg::WORD_W +: sit_pkg::WORD_W] = v;
        return sit_pkg::t_name'(bits);
    endfunction

    // mostly identifier-like names padded with zero bytes, some fully random
    function automatic sit_pkg::t_name fresh_name();
        logic [NAME_W-1:0] bits;
        int                len;
        bits = '0;
        if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < 6; k++)
                bits[k*sit_pkg::WORD_W +: sit_pkg::WORD_W] = $urandom;
        end else begin
            len = $urandom_range(1, 24);
            for (int k = 0; k < len; k++) bits[k*8 +: 8] = 8'($urandom_range(33, 126));
        end
        return sit_pkg::t_name'(bits);
    endfunction

    // new name, repeat of an earlier one, or an earlier one with a single bit flipped
    function automatic sit_pkg::t_name pick_name();
        logic [NAME_W-1:0] bits;
        int                roll;
        roll = $urandom_range(0, 99);
        if (sent_names.size() == 0 || roll < 50) return fresh_name();
        bits = sent_names[$urandom_range(0, sent_names.size() - 1)];
        if (roll < 65) bits[$urandom_range(0, NAME_W - 1)] ^= 1'b1;
        return sit_pkg::t_name'(bits);
    endfunction

    initial begin
        sit_pkg::t_opcode op;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = sit_pkg::OP_SEARCH;
        req_ch.name_word0 = '0;
        req_ch.name_word1 = '0;
        req_ch.name_word2 = '0;
        req_ch.name_word3 = '0;
        req_ch.name_word4 = '0;
        req_ch.name_word5 = '0;
        calm        = 1'b0;
        lazy        = 1'b1;
        hold_wanted = 1'b0;
        i_rst_n     = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, then the all-zero name stored like any other
        request(sit_pkg::OP_SEARCH, sit_pkg::t_name'({NAME_W{1'b0}}));
        request(sit_pkg::OP_INTERN, sit_pkg::t_name'({NAME_W{1'b0}}));
        request(sit_pkg::OP_SEARCH, sit_pkg::t_name'({NAME_W{1'b0}}));
        // all ones, and a second intern of it must not make a duplicate
        request(sit_pkg::OP_INTERN, sit_pkg::t_name'({NAME_W{1'b1}}));
        request(sit_pkg::OP_INTERN, sit_pkg::t_name'({NAME_W{1'b1}}));
        request(sit_pkg::OP_INTERN, sit_pkg::t_name'({6{32'hAAAA_AAAA}}));
        request(sit_pkg::OP_INTERN, sit_pkg::t_name'({6{32'h5555_5555}}));
        // names living in a single word, then misses by the top bit of that word
        for (int w = 0; w < 6; w++)
            request(sit_pkg::OP_INTERN, one_word_name(w, 32'h8000_0001));
        for (int w = 0; w < 6; w++)
            request(sit_pkg::OP_SEARCH, one_word_name(w, 32'h0000_0001));
        request(sit_pkg::OP_SEARCH, sit_pkg::t_name'({NAME_W{1'b1}}));

        // random traffic; the table fills part way through and stays full
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 50 == 0) lazy = 1'($urandom_range(0, 1));
            calm = (n >= N_RANDOM - CALM_ITEMS);
            // reply side holds off while requests keep coming, so the block backs up
            if (n == 400 || n == 1300) hold_wanted = 1'b1;
            op = ($urandom_range(0, 99) < 60) ? sit_pkg::OP_INTERN : sit_pkg::OP_SEARCH;
            request(op, pick_name());
        end
        req_ch.valid <= 1'b0;

        while (sb.outstanding() != 0) @(negedge i_clk);
        // a full scan more, so a stray reply would still be caught
        repeat (sit_pkg::ENTRIES + 20) @(negedge i_clk);

        $display("replies checked: %0d found, %0d inserted, %0d not found, %0d table full",
                 sb.tally[sit_pkg::ST_FOUND], sb.tally[sit_pkg::ST_INSERTED],
                 sb.tally[sit_pkg::ST_NOT_FOUND], sb.tally[sit_pkg::ST_FULL]);
        $display("table ended with %0d of %0d entries, %0d mismatches counted",
                 sb.known_count, sit_pkg::ENTRIES, sb.faults);
        if (sb.faults == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sit_pkg.sv
rtl/sit_if.sv
rtl/sit_ram.sv
rtl/sit_cmp.sv
rtl/sit_ctrl.sv
rtl/symbol_intern_table_core.sv
tb/symbol_intern_table_core_test.sv
